// ===== rtl/pmsp_pkg.sv =====
// Shared types and constants for the permission mode string parser.
package pmsp_pkg;

	// Full permission field: rwx for user, group and other.
	localparam logic [8:0] ALL_BITS = 9'o777;
	localparam logic [9:0] OCTAL_SAT = 10'd1023;
	localparam logic [2:0] FULL_CLASS = 3'd7;

	// ASCII codes recognized by the parser.
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_G = 8'h67;
	localparam logic [7:0] CH_O = 8'h6f;
	localparam logic [7:0] CH_A = 8'h61;
	localparam logic [7:0] CH_PLUS = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_EQUAL = 8'h3d;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_W = 8'h77;
	localparam logic [7:0] CH_X = 8'h78;

	// Operation of the current symbolic clause.
	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_ASSIGN = 2'd2
	} op_kind_t;

	// Error codes reported with each result.
	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_BAD_OCTAL  = 3'd1,
		ERR_BAD_CLASS  = 3'd2,
		ERR_BAD_OP     = 3'd3,
		ERR_BAD_PERM   = 3'd4
	} err_code_t;

	// Parse state carried from one character to the next.
	typedef struct packed {
		logic      numeric_mode;
		logic      in_mode_part;
		logic [2:0] class_set;
		op_kind_t  op_kind;
		logic [8:0] set_bits;
		logic [8:0] clr_bits;
		logic [9:0] octal_value;
		err_code_t error_latch;
	} parse_state_t;

	localparam parse_state_t PARSE_CLEAR = '{
		numeric_mode: 1'b0,
		in_mode_part: 1'b0,
		class_set:    3'd0,
		op_kind:      OP_ADD,
		set_bits:     9'd0,
		clr_bits:     9'd0,
		octal_value:  10'd0,
		error_latch:  ERR_NONE
	};

endpackage

// ===== rtl/pmsp_if.sv =====
// Valid/ready channel interfaces for characters in and masks out.
interface pmsp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       first_char;
	logic       last_char;
	logic       no_char;

	modport source (output valid, output character, output first_char, output last_char,
		output no_char, input ready);
	modport sink (input valid, input character, input first_char, input last_char,
		input no_char, output ready);
endinterface

interface pmsp_mask_if;
	logic       valid;
	logic       ready;
	logic [8:0] write_mask;
	logic [8:0] clear_mask;
	logic [2:0] error_code;

	modport source (output valid, output write_mask, output clear_mask, output error_code,
		input ready);
	modport sink (input valid, input write_mask, input clear_mask, input error_code,
		output ready);
endinterface

// ===== rtl/permission_mode_string_parser.sv =====
// Permission mode string parser: characters in, write and clear masks out.
//
// The chars channel takes one byte of a mode string per word, with marks for
// the first byte, the last byte and an empty string. The masks channel gives
// one word per string: write mask, clear mask and error code.
// A string whose first byte is a digit is read as octal; any other string is
// parsed as symbolic clauses such as u+rw,go=x.
// Throughput is one character per cycle. A character is captured in the
// input stage; when it moves on, the parse state and, for a last byte, the output
// register are updated, so a result passes through both registers before it is
// offered on the masks channel.
// The output register decouples the two sides: characters that produce no
// result keep flowing while a result waits. A character that produces a
// result holds in the input stage only while the output register is full
// and not being taken, and the chars channel then stalls behind it.
// Reset clears the parse state to an empty symbolic string and empties both
// stages; a string that starts without a first mark continues from the held
// state.
module permission_mode_string_parser
	import pmsp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	pmsp_char_if.sink          chars,
	pmsp_mask_if.source        masks
);

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         first_s1;
	logic         last_s1;
	logic         none_s1;

	parse_state_t state_q;
	parse_state_t state_nxt;

	logic         out_valid_q;
	logic [8:0]   write_mask_q;
	logic [8:0]   clear_mask_q;
	err_code_t    error_code_q;

	logic         emit;
	logic [8:0]   res_write;
	logic [8:0]   res_clear;
	err_code_t    res_error;
	logic         advance_s1;

	// The input stage moves on unless its result finds the output full.
	assign advance_s1 = valid_s1 && (!emit || !out_valid_q || masks.ready);
	assign chars.ready = !valid_s1 || advance_s1;

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1  <= chars.character;
			first_s1 <= chars.first_char;
			last_s1  <= chars.last_char;
			none_s1  <= chars.no_char;
		end
	end

	// Next parse state and result for the character in the input stage.
	always_comb begin
		parse_state_t st;
		logic [2:0]   perm;
		logic [2:0]   clr_pat;
		logic [8:0]   add_vec;
		logic [8:0]   clr_vec;

		st        = state_q;
		perm      = 3'd0;
		clr_pat   = 3'd0;
		add_vec   = 9'd0;
		clr_vec   = 9'd0;
		emit      = 1'b0;
		res_write = 9'd0;
		res_clear = 9'd0;
		res_error = ERR_NONE;

		if (none_s1) begin
			// Empty string: clear the parse and report an empty result.
			st   = PARSE_CLEAR;
			emit = 1'b1;
		end else begin
			if (first_s1) begin
				st = PARSE_CLEAR;
				st.numeric_mode = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
			end

			if (st.error_latch == ERR_NONE) begin
				if (st.numeric_mode) begin
					// Octal digit: shift in three bits, saturating at the top.
					if (char_s1 < CH_ZERO || char_s1 > CH_SEVEN) begin
						st.error_latch = ERR_BAD_OCTAL;
					end else if (st.octal_value[9:7] != 3'd0) begin
						st.octal_value = OCTAL_SAT;
					end else begin
						st.octal_value = {st.octal_value[6:0], char_s1[2:0]};
					end
				end else if (st.in_mode_part) begin
					// Permission letters, or a comma that opens a new clause.
					if (char_s1 == CH_COMMA) begin
						st.in_mode_part = 1'b0;
						st.class_set    = 3'd0;
						st.op_kind      = OP_ADD;
					end else if (char_s1 == CH_R || char_s1 == CH_W || char_s1 == CH_X) begin
						perm[2] = (char_s1 == CH_R);
						perm[1] = (char_s1 == CH_W);
						perm[0] = (char_s1 == CH_X);
						clr_pat = (st.op_kind == OP_ASSIGN) ? FULL_CLASS : perm;
						add_vec = {st.class_set[2] ? perm : 3'd0,
							st.class_set[1] ? perm : 3'd0,
							st.class_set[0] ? perm : 3'd0};
						clr_vec = {st.class_set[2] ? clr_pat : 3'd0,
							st.class_set[1] ? clr_pat : 3'd0,
							st.class_set[0] ? clr_pat : 3'd0};
						if (st.op_kind != OP_REMOVE) begin
							st.set_bits = st.set_bits | add_vec;
						end
						if (st.op_kind == OP_REMOVE || st.op_kind == OP_ASSIGN) begin
							st.clr_bits = st.clr_bits | clr_vec;
						end
					end else begin
						st.error_latch = ERR_BAD_PERM;
					end
				end else begin
					// Class letters, then the operation that ends the class part.
					priority if (char_s1 == CH_U) begin
						st.class_set[2] = 1'b1;
					end else if (char_s1 == CH_G) begin
						st.class_set[1] = 1'b1;
					end else if (char_s1 == CH_O) begin
						st.class_set[0] = 1'b1;
					end else if (char_s1 == CH_A) begin
						st.class_set = FULL_CLASS;
					end else if (char_s1 == CH_PLUS || char_s1 == CH_MINUS
						|| char_s1 == CH_EQUAL) begin
						if (char_s1 == CH_PLUS) begin
							st.op_kind = OP_ADD;
						end else if (char_s1 == CH_MINUS) begin
							st.op_kind = OP_REMOVE;
						end else begin
							st.op_kind = OP_ASSIGN;
						end
						if (st.class_set == 3'd0) begin
							st.class_set = FULL_CLASS;
						end
						st.in_mode_part = 1'b1;
					end else begin
						st.error_latch = (st.class_set == 3'd0) ? ERR_BAD_CLASS : ERR_BAD_OP;
					end
				end
			end

			// Last byte: form the result from the updated state.
			if (last_s1) begin
				emit      = 1'b1;
				res_error = st.error_latch;
				if (st.error_latch == ERR_NONE && st.numeric_mode) begin
					if (st.octal_value[9]) begin
						res_error = ERR_BAD_OCTAL;
					end
					res_write = st.octal_value[8:0];
					res_clear = ALL_BITS;
				end else begin
					res_write = st.set_bits;
					res_clear = st.clr_bits;
				end
				if (res_error != ERR_NONE) begin
					res_write = 9'd0;
					res_clear = 9'd0;
				end
			end
		end

		state_nxt = st;
	end

	// Parse state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PARSE_CLEAR;
		end else if (advance_s1) begin
			state_q <= state_nxt;
		end
	end

	// Output register: loaded by a result, emptied when the word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (masks.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && emit) begin
			write_mask_q <= res_write;
			clear_mask_q <= res_clear;
			error_code_q <= res_error;
		end
	end

	assign masks.valid      = out_valid_q;
	assign masks.write_mask = write_mask_q;
	assign masks.clear_mask = clear_mask_q;
	assign masks.error_code = error_code_q;

	// An error result carries empty masks.
	a_err_masks_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && error_code_q != ERR_NONE |-> write_mask_q == 9'd0 && clear_mask_q == 9'd0)
		else $error("error result with nonzero masks");

	// Octal and symbolic parsing never run at once.
	a_mode_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q.numeric_mode && state_q.in_mode_part))
		else $error("numeric mode and permission part both active");

	// The octal accumulator only moves in numeric mode.
	a_octal_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.numeric_mode |-> state_q.octal_value == 10'd0)
		else $error("octal value set outside numeric mode");

	// A symbolic clause in its permission part always has a class.
	a_class_in_perm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.in_mode_part |-> state_q.class_set != 3'd0)
		else $error("permission part without a class");

endmodule
